@@ src/bartmap_pkg.sv @@
package bartmap_pkg;

   localparam int MaxCategories = 64;
   localparam int MaxFeatures   = 32;
   localparam int LabelBits     = 8;
   localparam int IdxW          = $clog2(MaxCategories);
   localparam int TotW          = IdxW + 1;
   localparam int VecW          = 2 * MaxFeatures;
   localparam int CntW          = $clog2(VecW + 1);
   localparam int DenW          = 25;
   localparam int ThrW          = 40;

   // item kinds
   localparam logic [1:0] KIND_TRAIN   = 2'd0;
   localparam logic [1:0] KIND_PREDICT = 2'd1;
   localparam logic [1:0] KIND_LOAD    = 2'd2;

   // match tracking modes
   localparam logic [2:0] MT_PLUS  = 3'd0;
   localparam logic [2:0] MT_MINUS = 3'd1;
   localparam logic [2:0] MT_ZERO  = 3'd2;
   localparam logic [2:0] MT_ONE   = 3'd3;
   localparam logic [2:0] MT_NONE  = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // register indexes
   localparam logic [2:0] REG_VIGILANCE = 3'd0;
   localparam logic [2:0] REG_ALPHA     = 3'd1;
   localparam logic [2:0] REG_MODE      = 3'd2;
   localparam logic [2:0] REG_EPSILON   = 3'd3;
   localparam logic [2:0] REG_FEATURES  = 3'd4;

   typedef struct packed {
      logic [1:0]           kind;
      logic [VecW-1:0]      sample_bits;
      logic [LabelBits-1:0] class_label;
   } req_type;

   typedef struct packed {
      logic [IdxW-1:0]      category_index;
      logic [LabelBits-1:0] category_label;
      logic                 created_new;
      logic [1:0]           status;
   } rsp_type;

   function automatic logic [CntW-1:0] pop_count(input logic [VecW-1:0] v);
      logic [CntW-1:0] n;
      n = '0;
      for (int i = 0; i < VecW; i++) n = n + CntW'(v[i]);
      return n;
   endfunction

endpackage

@@ src/binary_artmap_classifier_top.sv @@
// Load: IDLE, EVAL, FIN. Predict: RD, POP and CMP for each of N stored categories,
// then EVAL and FIN. Train: each search pass steps RD, POP and CMP over the categories
// and ends in EVAL, up to N + 1 passes (the last one finds no candidate), then FIN;
// MT1 stops the search. One item at a time: req_stall is high until FIN issues the
// response; the single weight read port and shared score unit take categories in turn.
// Reset (synchronous, active high) clears control, count and registers to defaults;
// the weight and label stores are undefined until written.
module binary_artmap_classifier_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bartmap_pkg::req_type    req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output bartmap_pkg::rsp_type    rsp_payload,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [23:0]             csr_wdata
);
   import bartmap_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_POP  = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_EVAL = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   // configuration
   logic [16:0] vig_ff;
   logic [23:0] alpha_ff;
   logic [2:0]  mode_ff;
   logic [16:0] eps_ff;
   logic [5:0]  feat_ff;

   // stores
   logic [VecW-1:0]      wmem [MaxCategories];
   logic [LabelBits-1:0] lmem [MaxCategories];
   logic [VecW-1:0]      wrd_ff;
   logic [LabelBits-1:0] lrd_ff;

   // control and working registers
   logic [2:0]           state_ff, state_in;
   logic [TotW-1:0]      total_ff, total_in;
   logic [IdxW-1:0]      scan_ff, scan_in;
   logic [MaxCategories-1:0] visited_ff, visited_in;
   logic                 have_ff, have_in;
   logic [1:0]           kind_ff, kind_in;
   logic [VecW-1:0]      x_ff, x_in, vm_ff, vm_in;
   logic [LabelBits-1:0] lab_ff, lab_in;
   logic [2:0]           mode_w_ff, mode_w_in;
   logic [22:0]          vigf_ff, vigf_in, epsf_ff, epsf_in;
   logic signed [ThrW-1:0] thr_ff, thr_in;
   logic [CntW-1:0]      cw1_ff, cw1_in;
   logic [DenW-1:0]      cd_ff, cd_in;
   logic [CntW-1:0]      bw1_ff, bw1_in;
   logic [DenW-1:0]      bd_ff, bd_in;
   logic [IdxW-1:0]      bidx_ff, bidx_in;
   logic [LabelBits-1:0] blab_ff, blab_in;
   logic [VecW-1:0]      bw_ff, bw_in;
   rsp_type              res_ff, res_in;
   logic                 rvalid_ff, rvalid_in;
   rsp_type              out_ff, out_in;

   // memory write request
   logic                 we;
   logic [IdxW-1:0]      waddr;
   logic [VecW-1:0]      wdata;
   logic                 lwe;

   // helpers
   logic [5:0]           feff;
   logic [VecW-1:0]      vmask;
   logic [2:0]           mode_n;
   logic                 strict;
   logic [CntW-1:0]      s_cnt;
   logic [DenW-1:0]      d_raw;
   logic [32:0]          prod_a, prod_b;
   logic                 beats, elig;
   logic signed [ThrW-1:0] m_s;
   logic                 pass;

   assign csr_ready   = 1'b1;
   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rvalid_ff;
   assign rsp_payload = out_ff;

   // effective feature count, vector mask and match tracking mode
   always_comb begin
      feff = (feat_ff == 6'd0) ? 6'd1 :
             (feat_ff > 6'(MaxFeatures)) ? 6'(MaxFeatures) : feat_ff;
      vmask = (feff >= 6'(MaxFeatures)) ? '1 : ((VecW'(1) << (7'(feff) << 1)) - VecW'(1));
      mode_n = (mode_ff > MT_NONE) ? MT_PLUS : mode_ff;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vig_ff   <= 17'd49152;
         alpha_ff <= 24'd66;
         mode_ff  <= MT_PLUS;
         eps_ff   <= 17'd66;
         feat_ff  <= 6'd32;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_VIGILANCE: vig_ff   <= csr_wdata[16:0];
            REG_ALPHA:     alpha_ff <= csr_wdata;
            REG_MODE:      mode_ff  <= csr_wdata[2:0];
            REG_EPSILON:   eps_ff   <= csr_wdata[16:0];
            REG_FEATURES:  feat_ff  <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // stores: one write port, registered read at the scan index
   always_ff @(posedge clock) begin
      if (we) wmem[waddr] <= wdata;
      if (lwe) lmem[waddr] <= lab_ff;
      wrd_ff <= wmem[scan_ff];
      lrd_ff <= lmem[scan_ff];
   end

   // shared score unit
   always_comb begin
      strict = (mode_w_ff == MT_ZERO) || (mode_w_ff == MT_NONE);
      s_cnt  = pop_count(wrd_ff & vm_ff);
      d_raw  = DenW'(alpha_ff) + (DenW'(s_cnt) << 16);
      prod_a = 33'(cw1_ff) * 33'(bd_ff);
      prod_b = 33'(bw1_ff) * 33'(cd_ff);
      beats  = prod_a > prod_b;
      if (kind_ff == KIND_PREDICT) elig = 1'b1;
      else begin
         elig = !visited_ff[scan_ff] && ((mode_w_ff == MT_MINUS) ||
                (strict ? (cw1_ff > vigf_ff[22:16]) : (cw1_ff >= vigf_ff[22:16])));
      end
      m_s  = ThrW'(signed'({1'b0, bw1_ff, 16'd0}));
      pass = strict ? (m_s > thr_ff) : (m_s >= thr_ff);
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      total_in   = total_ff;
      scan_in    = scan_ff;
      visited_in = visited_ff;
      have_in    = have_ff;
      kind_in    = kind_ff;
      x_in       = x_ff;
      vm_in      = vm_ff;
      lab_in     = lab_ff;
      mode_w_in  = mode_w_ff;
      vigf_in    = vigf_ff;
      epsf_in    = epsf_ff;
      thr_in     = thr_ff;
      cw1_in     = cw1_ff;
      cd_in      = cd_ff;
      bw1_in     = bw1_ff;
      bd_in      = bd_ff;
      bidx_in    = bidx_ff;
      blab_in    = blab_ff;
      bw_in      = bw_ff;
      res_in     = res_ff;
      rvalid_in  = rvalid_ff;
      out_in     = out_ff;
      we         = 1'b0;
      lwe        = 1'b0;
      waddr      = total_ff[IdxW-1:0];
      wdata      = x_ff;

      if (rvalid_ff && !rsp_stall) rvalid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_payload.kind;
               x_in      = req_payload.sample_bits & vmask;
               vm_in     = vmask;
               lab_in    = req_payload.class_label;
               mode_w_in = mode_n;
               vigf_in   = 23'(vig_ff) * 23'(feff);
               epsf_in   = 23'(eps_ff) * 23'(feff);
               state_in  = S_FIN;
               scan_in   = '0;
               have_in   = 1'b0;
               visited_in = '0;
               res_in    = '0;
               case (req_payload.kind)
                  KIND_TRAIN: begin
                     thr_in = ThrW'(23'(vig_ff) * 23'(feff));
                     if (total_ff != '0) state_in = S_RD;
                     else state_in = S_EVAL;
                  end
                  KIND_PREDICT: begin
                     if (total_ff != '0) state_in = S_RD;
                     else res_in.status = ST_EMPTY;
                  end
                  KIND_LOAD: state_in = S_EVAL;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_RD: state_in = S_POP;
         S_POP: begin
            cw1_in   = pop_count(x_ff & wrd_ff);
            cd_in    = (d_raw == '0) ? DenW'(1) : d_raw;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (elig && (!have_ff || beats)) begin
               have_in = 1'b1;
               bw1_in  = cw1_ff;
               bd_in   = cd_ff;
               bidx_in = scan_ff;
               blab_in = lrd_ff;
               bw_in   = wrd_ff;
            end
            if (TotW'(scan_ff) + TotW'(1) == total_ff) state_in = S_EVAL;
            else begin
               scan_in  = scan_ff + IdxW'(1);
               state_in = S_RD;
            end
         end
         S_EVAL: begin
            state_in = S_FIN;
            if (kind_ff == KIND_PREDICT) begin
               res_in = '{bidx_ff, blab_ff, 1'b0, ST_OK};
            end else if (kind_ff == KIND_TRAIN && have_ff) begin
               visited_in[bidx_ff] = 1'b1;
               have_in  = 1'b0;
               scan_in  = '0;
               state_in = S_RD;
               if (pass) begin
                  if (blab_ff == lab_ff) begin
                     we       = 1'b1;
                     waddr    = bidx_ff;
                     wdata    = bw_ff & x_ff;
                     res_in   = '{bidx_ff, lab_ff, 1'b0, ST_OK};
                     state_in = S_FIN;
                  end else begin
                     case (mode_w_ff)
                        MT_PLUS:  thr_in = m_s + ThrW'(epsf_ff);
                        MT_MINUS: thr_in = m_s - ThrW'(epsf_ff);
                        MT_ZERO:  thr_in = m_s;
                        MT_ONE: begin
                           have_in  = 1'b0;
                           state_in = S_EVAL;
                           kind_in  = KIND_LOAD;
                        end
                        default: ;
                     endcase
                  end
               end
            end else begin
               // append a new category (load, or train with no winner), or report ST_FULL when full
               if (total_ff >= TotW'(MaxCategories)) res_in = '{'0, '0, 1'b0, ST_FULL};
               else begin
                  we       = 1'b1;
                  lwe      = 1'b1;
                  total_in = total_ff + TotW'(1);
                  res_in   = '{total_ff[IdxW-1:0], lab_ff, 1'b1, ST_OK};
               end
            end
         end
         S_FIN: begin
            if (!rvalid_ff || !rsp_stall) begin
               rvalid_in = 1'b1;
               out_in    = res_ff;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         total_ff   <= '0;
         visited_ff <= '0;
         have_ff    <= 1'b0;
         rvalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         total_ff   <= total_in;
         visited_ff <= visited_in;
         have_ff    <= have_in;
         rvalid_ff  <= rvalid_in;
      end
      scan_ff   <= scan_in;
      kind_ff   <= kind_in;
      x_ff      <= x_in;
      vm_ff     <= vm_in;
      lab_ff    <= lab_in;
      mode_w_ff <= mode_w_in;
      vigf_ff   <= vigf_in;
      epsf_ff   <= epsf_in;
      thr_ff    <= thr_in;
      cw1_ff    <= cw1_in;
      cd_ff     <= cd_in;
      bw1_ff    <= bw1_in;
      bd_ff     <= bd_in;
      bidx_ff   <= bidx_in;
      blab_ff   <= blab_in;
      bw_ff     <= bw_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
   end

   // checks
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TotW'(MaxCategories)) else $error("category count overflow");
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (TotW'(scan_ff) < total_ff)) else $error("scan past count");
   a_created_ok: assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && out_ff.created_new) |-> (out_ff.status == ST_OK))
      else $error("created with bad status");
   a_append_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && lwe) |=> (total_ff == $past(total_ff) + TotW'(1)))
      else $error("append did not count");

endmodule
